// ----- sv/row_frame_encoder_core_defines.svh -----
// Assertion macros shared by the encoder RTL
`ifndef ROW_FRAME_ENCODER_CORE_DEFINES_SVH
`define ROW_FRAME_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define RFE_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rfe_pkg.sv -----
package rfe_pkg;

   localparam int STORE_BYTES = 4096;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PTR_W       = ADDR_W + 1;

   localparam logic [PTR_W-1:0] STORE_END = PTR_W'(STORE_BYTES);

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_PULL = 2'd2;

   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] BYTE_MAX  = 8'hFF;

   localparam int ERR_TEXT_LEN  = 36;
   localparam int ERR_FRAME_LEN = ERR_TEXT_LEN + 3;
   localparam int ERR_IDX_W     = $clog2(ERR_FRAME_LEN);

   localparam logic [8*ERR_TEXT_LEN-1:0] ERR_TEXT = "RCON response exceeds protocol limit";
   localparam logic [7:0] ERR_COUNT_BYTE = 8'h01;
   localparam logic [7:0] ERR_LEN_BYTE   = 8'(ERR_TEXT_LEN + 1);

   localparam logic [ERR_IDX_W-1:0] ERR_TEXT_FIRST = ERR_IDX_W'(2);
   localparam logic [ERR_IDX_W-1:0] ERR_TEXT_TOP   = ERR_IDX_W'(ERR_TEXT_LEN + 1);
   localparam logic [ADDR_W-1:0]    ERR_RP_END     = ADDR_W'(ERR_FRAME_LEN);
   localparam logic [PTR_W-1:0]     ERR_FRAME_END  = PTR_W'(ERR_FRAME_LEN);

   function automatic logic [7:0] err_byte(input logic [ERR_IDX_W-1:0] idx);
      logic [7:0] b;
      b = CHAR_NUL;
      if (idx == '0) begin
         b = ERR_COUNT_BYTE;
      end else if (idx == ERR_IDX_W'(1)) begin
         b = ERR_LEN_BYTE;
      end else if (idx inside {[ERR_TEXT_FIRST:ERR_TEXT_TOP]}) begin
         b = ERR_TEXT[{(ERR_TEXT_TOP - idx), 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage

// ----- sv/row_frame_encoder_core.sv -----
// Row frame encoder.
// Request channel (req_): req_kind 0 carries one message byte in req_data_byte,
// 1 ends the message, 2 pulls the next frame byte. Response channel (rsp_):
// one word per pull with rsp_out_byte, rsp_frame_end on the last frame byte,
// and rsp_status 1 when no finished frame is waiting.
// Writes per request, one at a time through the single write port of the
// frame store: a message byte writes once, a newline writes a zero byte, then
// the row length byte, end of message up to the zero, length and count bytes.
// Pull responses: status and error frame bytes load straight into the output
// register; a stored byte passes through the store read register first.
// Throughput is one word per cycle for non-newline message bytes while no
// response is held; newlines and stored-byte pulls hold off the next request.
// Synchronous reset empties the frame and drops a pending response; the store
// itself needs no clearing, only bytes of the current frame are read back.
// A stalled response holds in the output register; req_stall rises until it
// is taken. After the last frame byte is pulled the block is ready for a new
// message.
`include "row_frame_encoder_core_defines.svh"

module row_frame_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end,
   output logic       rsp_status
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_ROW_LEN = 5'b00010,
      ST_EOM_LEN = 5'b00100,
      ST_COUNT   = 5'b01000,
      ST_READ    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [rfe_pkg::PTR_W-1:0]  write_pointer_ff, write_pointer_in;
   logic [rfe_pkg::ADDR_W-1:0] row_start_ff, row_start_in;
   logic [7:0]                 row_length_ff, row_length_in;
   logic [7:0]                 row_count_ff, row_count_in;
   logic                       row_open_ff, row_open_in;
   logic                       carriage_ff, carriage_in;
   logic                       limit_error_ff, limit_error_in;
   logic                       draining_ff, draining_in;
   logic [rfe_pkg::ADDR_W-1:0] read_pointer_ff, read_pointer_in;
   logic [7:0]                 pend_len_ff, pend_len_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_status_ff, rsp_status_in;

   logic                       ram_wr_en;
   logic [rfe_pkg::ADDR_W-1:0] ram_wr_addr;
   logic [7:0]                 ram_wr_data;
   logic [7:0]                 ram_rd_data;

   logic                       req_take;
   logic                       op_fail;
   logic [rfe_pkg::PTR_W-1:0]  op_wp;
   logic [rfe_pkg::ADDR_W-1:0] op_start;
   logic [7:0]                 op_len;
   logic [7:0]                 op_count;
   logic                       op_cp;
   logic [7:0]                 cl_kept;
   logic [rfe_pkg::PTR_W-1:0]  cl_wp;
   logic                       cl_fail;
   logic                       pull_last;

   rfe_ram #(
      .WIDTH(8),
      .DEPTH(rfe_pkg::STORE_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(read_pointer_ff),
      .rd_data(ram_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_frame_end = rsp_end_ff;
   assign rsp_status    = rsp_status_ff;

   // row as it stands once a message byte has opened it
   always_comb begin
      op_fail  = 1'b0;
      op_wp    = write_pointer_ff;
      op_start = row_start_ff;
      op_len   = row_length_ff;
      op_count = row_count_ff;
      op_cp    = carriage_ff;
      if (!row_open_ff) begin
         if (row_count_ff == rfe_pkg::BYTE_MAX || write_pointer_ff >= rfe_pkg::STORE_END) begin
            op_fail = 1'b1;
         end else begin
            op_count = row_count_ff + 8'd1;
            op_start = write_pointer_ff[rfe_pkg::ADDR_W-1:0];
            op_wp    = write_pointer_ff + rfe_pkg::PTR_W'(1);
            op_len   = 8'd0;
            op_cp    = 1'b0;
         end
      end
   end

   // drop a trailing carriage return on close
   always_comb begin
      cl_kept = op_len;
      cl_wp   = op_wp;
      if (op_cp && op_len != 8'd0) begin
         cl_kept = op_len - 8'd1;
         cl_wp   = op_wp - rfe_pkg::PTR_W'(1);
      end
      cl_fail = (cl_kept == rfe_pkg::BYTE_MAX) || (cl_wp >= rfe_pkg::STORE_END);
   end

   always_comb begin
      if (limit_error_ff) begin
         pull_last = ({1'b0, read_pointer_ff} + rfe_pkg::PTR_W'(1)) >= rfe_pkg::ERR_FRAME_END;
      end else begin
         pull_last = ({1'b0, read_pointer_ff} + rfe_pkg::PTR_W'(1)) >= write_pointer_ff;
      end
   end

   always_comb begin
      state_in         = state_ff;
      write_pointer_in = write_pointer_ff;
      row_start_in     = row_start_ff;
      row_length_in    = row_length_ff;
      row_count_in     = row_count_ff;
      row_open_in      = row_open_ff;
      carriage_in      = carriage_ff;
      limit_error_in   = limit_error_ff;
      draining_in      = draining_ff;
      read_pointer_in  = read_pointer_ff;
      pend_len_in      = pend_len_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_byte_in      = rsp_byte_ff;
      rsp_end_in       = rsp_end_ff;
      rsp_status_in    = rsp_status_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = '0;
      ram_wr_data      = rfe_pkg::CHAR_NUL;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_kind)
                  rfe_pkg::KIND_BYTE: begin
                     if (!draining_ff && !limit_error_ff) begin
                        row_count_in = op_count;
                        row_start_in = op_start;
                        row_open_in  = 1'b1;
                        if (op_fail) begin
                           limit_error_in = 1'b1;
                           row_count_in   = row_count_ff;
                           row_start_in   = row_start_ff;
                           row_open_in    = row_open_ff;
                        end else if (req_data_byte == rfe_pkg::CHAR_LF) begin
                           write_pointer_in = op_wp;
                           row_length_in    = op_len;
                           carriage_in      = op_cp;
                           if (cl_fail) begin
                              limit_error_in = 1'b1;
                           end else begin
                              ram_wr_en        = 1'b1;
                              ram_wr_addr      = cl_wp[rfe_pkg::ADDR_W-1:0];
                              write_pointer_in = cl_wp + rfe_pkg::PTR_W'(1);
                              pend_len_in      = cl_kept + 8'd1;
                              row_open_in      = 1'b0;
                              carriage_in      = 1'b0;
                              row_length_in    = 8'd0;
                              state_in         = ST_ROW_LEN;
                           end
                        end else begin
                           write_pointer_in = op_wp;
                           row_length_in    = op_len;
                           carriage_in      = op_cp;
                           if (op_len == rfe_pkg::BYTE_MAX || op_wp >= rfe_pkg::STORE_END) begin
                              limit_error_in = 1'b1;
                           end else begin
                              ram_wr_en        = 1'b1;
                              ram_wr_addr      = op_wp[rfe_pkg::ADDR_W-1:0];
                              ram_wr_data      = req_data_byte;
                              write_pointer_in = op_wp + rfe_pkg::PTR_W'(1);
                              row_length_in    = op_len + 8'd1;
                              carriage_in      = (req_data_byte == rfe_pkg::CHAR_CR);
                           end
                        end
                     end
                  end
                  rfe_pkg::KIND_END: begin
                     if (!draining_ff) begin
                        draining_in     = 1'b1;
                        read_pointer_in = '0;
                        if (!limit_error_ff && row_open_ff) begin
                           if (cl_fail) begin
                              limit_error_in = 1'b1;
                           end else begin
                              ram_wr_en        = 1'b1;
                              ram_wr_addr      = cl_wp[rfe_pkg::ADDR_W-1:0];
                              write_pointer_in = cl_wp + rfe_pkg::PTR_W'(1);
                              pend_len_in      = cl_kept + 8'd1;
                              row_open_in      = 1'b0;
                              carriage_in      = 1'b0;
                              row_length_in    = 8'd0;
                              state_in         = ST_EOM_LEN;
                           end
                        end else if (!limit_error_ff) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = '0;
                           ram_wr_data = row_count_ff;
                        end
                     end
                  end
                  rfe_pkg::KIND_PULL: begin
                     if (!draining_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = rfe_pkg::CHAR_NUL;
                        rsp_end_in    = 1'b0;
                        rsp_status_in = 1'b1;
                     end else begin
                        read_pointer_in = read_pointer_ff + rfe_pkg::ADDR_W'(1);
                        rsp_end_in      = pull_last;
                        rsp_status_in   = 1'b0;
                        if (limit_error_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_byte_in  = rfe_pkg::err_byte(
                              read_pointer_ff[rfe_pkg::ERR_IDX_W-1:0]);
                        end else begin
                           state_in = ST_READ;
                        end
                        if (pull_last) begin
                           write_pointer_in = rfe_pkg::PTR_W'(1);
                           row_start_in     = '0;
                           row_length_in    = 8'd0;
                           row_count_in     = 8'd0;
                           row_open_in      = 1'b0;
                           carriage_in      = 1'b0;
                           limit_error_in   = 1'b0;
                           draining_in      = 1'b0;
                           read_pointer_in  = '0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROW_LEN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = row_start_ff;
            ram_wr_data = pend_len_ff;
            state_in    = ST_IDLE;
         end
         ST_EOM_LEN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = row_start_ff;
            ram_wr_data = pend_len_ff;
            state_in    = ST_COUNT;
         end
         ST_COUNT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = row_count_ff;
            state_in    = ST_IDLE;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = ram_rd_data;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         write_pointer_ff <= rfe_pkg::PTR_W'(1);
         row_start_ff     <= '0;
         row_length_ff    <= 8'd0;
         row_count_ff     <= 8'd0;
         row_open_ff      <= 1'b0;
         carriage_ff      <= 1'b0;
         limit_error_ff   <= 1'b0;
         draining_ff      <= 1'b0;
         read_pointer_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         write_pointer_ff <= write_pointer_in;
         row_start_ff     <= row_start_in;
         row_length_ff    <= row_length_in;
         row_count_ff     <= row_count_in;
         row_open_ff      <= row_open_in;
         carriage_ff      <= carriage_in;
         limit_error_ff   <= limit_error_in;
         draining_ff      <= draining_in;
         read_pointer_ff  <= read_pointer_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_len_ff   <= pend_len_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
   end

   `RFE_ASSERT_HOLDS(a_no_write_in_drain, clock, reset, ram_wr_en && state_ff == ST_IDLE, !draining_ff, "frame store written while draining")
   `RFE_ASSERT_NEXT(a_read_fills_rsp, clock, reset, state_ff == ST_READ, rsp_valid_ff, "stored byte read without response")
   `RFE_ASSERT_HOLDS(a_wp_in_store, clock, reset, !limit_error_ff, write_pointer_ff <= rfe_pkg::STORE_END, "write pointer beyond store")
   `RFE_ASSERT_HOLDS(a_err_rp_bound, clock, reset, limit_error_ff && draining_ff, read_pointer_ff < rfe_pkg::ERR_RP_END, "error frame read beyond its end")

endmodule

// ----- sv/rfe_ram.sv -----
module rfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/tb_row_frame_encoder_core.sv -----
`timescale 1ns / 1ps

module tb_row_frame_encoder_core;

   localparam int          CLK_PERIOD  = 8;
   localparam int          CYCLE_LIMIT = 1_500_000;
   localparam int          RAND_WORDS  = 800;
   localparam int          CALM_WORDS  = 700;
   localparam int          DRAIN_WAIT  = 24;
   localparam logic [1:0]  KIND_NONE   = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       status;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       typed;
      rsp_type    exp;
   } word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] reps;
      logic        typed;
      rsp_type     exp;
   } row_type;

   typedef enum {
      SHAPE_SHORT,
      SHAPE_ROWS_MAX,
      SHAPE_ROW_MAX,
      SHAPE_ROW_OVER,
      SHAPE_ROWS_OVER,
      SHAPE_STORE_OVER
   } shape_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = rfe_pkg::KIND_BYTE;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_end;
   logic       rsp_status;

   row_frame_encoder_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_status    (rsp_status)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // encoder image
   logic [7:0]                frame_mem [0:rfe_pkg::STORE_BYTES-1];
   logic [7:0]                err_frame [0:rfe_pkg::ERR_FRAME_LEN-1];
   logic [rfe_pkg::PTR_W-1:0] wr_ptr;
   logic [rfe_pkg::PTR_W-1:0] rd_ptr;
   logic [rfe_pkg::ADDR_W-1:0] row_base;
   logic [7:0]                row_len;
   logic [8:0]                rows;
   logic                      row_live;
   logic                      cr_pend;
   logic                      lim_err;
   logic                      drain;

   rsp_type  frame_bytes_q [$];
   word_type stim_q [$];
   int    rand_words = 0;
   int    msg_count = 0;
   int    fail_count = 0;
   int    cycle_count = 0;
   int    stall_left = 0;
   bit    idle_on = 1'b1;

   row_type dir_rows [28] = '{
      '{rfe_pkg::KIND_PULL, 8'h00, 16'd1, 1'b1, '{rfe_pkg::CHAR_NUL, 1'b0, 1'b1}},
      '{KIND_NONE, 8'hFF, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_END, 8'h00, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_PULL, 8'h00, 16'd1, 1'b1, '{rfe_pkg::CHAR_NUL, 1'b1, 1'b0}},
      '{rfe_pkg::KIND_BYTE, 8'h41, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_CR, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_LF, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_CR, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_NUL, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::BYTE_MAX, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_LF, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_CR, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_END, 8'hFF, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, 8'h78, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_END, 8'h00, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_PULL, 8'hFF, 16'd11, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, 8'h5A, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_LF, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_END, 8'h00, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_PULL, 8'h00, 16'd4, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, 8'h61, 16'd256, 1'b0, '0},
      '{rfe_pkg::KIND_END, 8'h00, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_PULL, 8'h00, 16'd1, 1'b1, '{rfe_pkg::ERR_COUNT_BYTE, 1'b0, 1'b0}},
      '{rfe_pkg::KIND_PULL, 8'h00, 16'd1, 1'b1, '{rfe_pkg::ERR_LEN_BYTE, 1'b0, 1'b0}},
      '{rfe_pkg::KIND_PULL, 8'h00, 16'd37, 1'b0, '0},
      '{rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_LF, 16'd256, 1'b0, '0},
      '{rfe_pkg::KIND_END, 8'h00, 16'd1, 1'b0, '0},
      '{rfe_pkg::KIND_PULL, 8'h00, 16'd39, 1'b0, '0}
   };

   function automatic logic [rfe_pkg::PTR_W-1:0] frame_len();
      return lim_err ? rfe_pkg::ERR_FRAME_END : wr_ptr;
   endfunction

   task automatic clear_frame();
      wr_ptr   = rfe_pkg::PTR_W'(1);
      rd_ptr   = '0;
      row_base = '0;
      row_len  = '0;
      rows     = '0;
      row_live = 1'b0;
      cr_pend  = 1'b0;
      lim_err  = 1'b0;
      drain    = 1'b0;
   endtask

   task automatic close_row();
      logic [7:0] kept;
      if (lim_err || !row_live) return;
      kept = row_len;
      if (cr_pend && kept != 8'd0) begin
         kept   = kept - 8'd1;
         wr_ptr = wr_ptr - rfe_pkg::PTR_W'(1);
      end
      if (kept >= rfe_pkg::BYTE_MAX || wr_ptr >= rfe_pkg::STORE_END) begin
         lim_err = 1'b1;
         return;
      end
      frame_mem[wr_ptr[rfe_pkg::ADDR_W-1:0]] = rfe_pkg::CHAR_NUL;
      wr_ptr              = wr_ptr + rfe_pkg::PTR_W'(1);
      frame_mem[row_base] = kept + 8'd1;
      row_live            = 1'b0;
      cr_pend             = 1'b0;
      row_len             = '0;
   endtask

   task automatic frame_encode(input logic [1:0] kind, input logic [7:0] c,
                               output bit produced, output rsp_type r);
      bit blocked;
      produced = 1'b0;
      blocked  = 1'b0;
      r        = '0;
      case (kind)
         rfe_pkg::KIND_BYTE: begin
            if (!drain && !lim_err) begin
               if (!row_live) begin
                  if (rows >= 9'(rfe_pkg::BYTE_MAX) || wr_ptr >= rfe_pkg::STORE_END) begin
                     lim_err = 1'b1;
                     blocked = 1'b1;
                  end else begin
                     rows     = rows + 9'd1;
                     row_base = wr_ptr[rfe_pkg::ADDR_W-1:0];
                     wr_ptr   = wr_ptr + rfe_pkg::PTR_W'(1);
                     row_len  = '0;
                     cr_pend  = 1'b0;
                     row_live = 1'b1;
                  end
               end
               if (!blocked) begin
                  if (c == rfe_pkg::CHAR_LF) begin
                     close_row();
                  end else if (row_len >= rfe_pkg::BYTE_MAX ||
                               wr_ptr >= rfe_pkg::STORE_END) begin
                     lim_err = 1'b1;
                  end else begin
                     frame_mem[wr_ptr[rfe_pkg::ADDR_W-1:0]] = c;
                     wr_ptr  = wr_ptr + rfe_pkg::PTR_W'(1);
                     row_len = row_len + 8'd1;
                     cr_pend = (c == rfe_pkg::CHAR_CR);
                  end
               end
            end
         end
         rfe_pkg::KIND_END: begin
            if (!drain) begin
               close_row();
               if (!lim_err) frame_mem[0] = rows[7:0];
               drain  = 1'b1;
               rd_ptr = '0;
            end
         end
         rfe_pkg::KIND_PULL: begin
            produced = 1'b1;
            if (!drain) begin
               r.status = 1'b1;
            end else begin
               r.out_byte  = lim_err ? err_frame[rd_ptr]
                                     : frame_mem[rd_ptr[rfe_pkg::ADDR_W-1:0]];
               r.frame_end = (int'(rd_ptr) + 1 >= int'(frame_len()));
               rd_ptr      = rd_ptr + rfe_pkg::PTR_W'(1);
               if (r.frame_end) clear_frame();
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [7:0] any_but_lf();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      return (c == rfe_pkg::CHAR_LF) ? rfe_pkg::CHAR_CR : c;
   endfunction

   function automatic logic [7:0] msg_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) return rfe_pkg::CHAR_LF;
      if (pick < 35) return rfe_pkg::CHAR_CR;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_word(input logic [1:0] k, input logic [7:0] d, input bit counted);
      word_type w;
      w      = '0;
      w.kind = k;
      w.data = d;
      stim_q = {stim_q, w};
      if (counted) rand_words++;
   endtask

   // queue the next burst of words from where the encoder image stands
   task automatic plan_words();
      int        left;
      int        n;
      int        i;
      int        j;
      int        row_n;
      bit        big;
      shape_type shape;
      if (drain) begin
         left = int'(frame_len()) - int'(rd_ptr);
         big  = (int'(frame_len()) > 300);
         n    = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, left)) : left;
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               push_word($urandom_range(0, 1) ? rfe_pkg::KIND_END : rfe_pkg::KIND_BYTE,
                         8'($urandom_range(0, 255)), 1'b0);
            end
            push_word(rfe_pkg::KIND_PULL, 8'($urandom_range(0, 255)), !big);
         end
      end else begin
         msg_count++;
         case (msg_count)
            3:       shape = SHAPE_ROWS_MAX;
            5:       shape = SHAPE_ROW_MAX;
            7:       shape = SHAPE_ROW_OVER;
            9:       shape = SHAPE_ROWS_OVER;
            11:      shape = SHAPE_STORE_OVER;
            default: shape = SHAPE_SHORT;
         endcase
         case (shape)
            SHAPE_SHORT: begin
               n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(31, 120))
                                               : int'($urandom_range(0, 30));
               for (i = 0; i < n; i++) begin
                  if ($urandom_range(0, 19) == 0)
                     push_word(rfe_pkg::KIND_PULL, 8'($urandom_range(0, 255)), 1'b1);
                  if ($urandom_range(0, 39) == 0)
                     push_word(KIND_NONE, 8'($urandom_range(0, 255)), 1'b0);
                  push_word(rfe_pkg::KIND_BYTE, msg_char(), 1'b1);
               end
            end
            SHAPE_ROWS_MAX, SHAPE_ROWS_OVER: begin
               row_n = (shape == SHAPE_ROWS_MAX) ? 255 : 256;
               for (i = 0; i < row_n; i++) begin
                  n = $urandom_range(0, 2);
                  for (j = 0; j < n; j++)
                     push_word(rfe_pkg::KIND_BYTE, any_but_lf(), 1'b0);
                  push_word(rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_LF, 1'b0);
               end
            end
            SHAPE_ROW_MAX: begin
               for (i = 0; i < 254; i++) push_word(rfe_pkg::KIND_BYTE, any_but_lf(), 1'b0);
               push_word(rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_CR, 1'b0);
               push_word(rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_LF, 1'b0);
               push_word(rfe_pkg::KIND_BYTE, any_but_lf(), 1'b0);
            end
            SHAPE_ROW_OVER: begin
               for (i = 0; i < 255; i++) push_word(rfe_pkg::KIND_BYTE, any_but_lf(), 1'b0);
               for (i = 0; i < 4; i++) push_word(rfe_pkg::KIND_BYTE, msg_char(), 1'b0);
            end
            default: begin
               for (i = 0; i < 21; i++) begin
                  for (j = 0; j < 200; j++)
                     push_word(rfe_pkg::KIND_BYTE, any_but_lf(), 1'b0);
                  push_word(rfe_pkg::KIND_BYTE, rfe_pkg::CHAR_LF, 1'b0);
               end
            end
         endcase
         push_word(rfe_pkg::KIND_END, 8'($urandom_range(0, 255)), shape == SHAPE_SHORT);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_q.size() == 0) begin
            $error("unexpected word: out_byte %02h frame_end %0b status %0b",
                   rsp_out_byte, rsp_frame_end, rsp_status);
            fail_count++;
         end else begin
            want = frame_bytes_q.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte expected %02h actual %02h", want.out_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end expected %0b actual %0b", want.frame_end, rsp_frame_end);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0b actual %0b", want.status, rsp_status);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19);
      end
      rsp_stall <= (stall_left > 0);
   end

   initial begin : req_side
      word_type w;
      rsp_type  r;
      bit       got;
      bit       in_random;
      int       i;
      int       k;
      in_random = 1'b0;
      err_frame[0] = rfe_pkg::ERR_COUNT_BYTE;
      err_frame[1] = rfe_pkg::ERR_LEN_BYTE;
      for (i = 0; i < rfe_pkg::ERR_TEXT_LEN; i++)
         err_frame[i + 2] = rfe_pkg::ERR_TEXT[8 * (rfe_pkg::ERR_TEXT_LEN - 1 - i) +: 8];
      err_frame[rfe_pkg::ERR_FRAME_LEN - 1] = rfe_pkg::CHAR_NUL;
      clear_frame();
      for (i = 0; i < $size(dir_rows); i++) begin
         for (k = 0; k < int'(dir_rows[i].reps); k++) begin
            w.kind  = dir_rows[i].kind;
            w.data  = dir_rows[i].data;
            w.typed = dir_rows[i].typed;
            w.exp   = dir_rows[i].exp;
            stim_q  = {stim_q, w};
         end
      end
      in_random = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0) begin
         w = stim_q.pop_front();
         if (idle_on && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_kind      <= w.kind;
         req_data_byte <= w.data;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         frame_encode(w.kind, w.data, got, r);
         if (got) frame_bytes_q = {frame_bytes_q, (w.typed ? w.exp : r)};
         idle_on = (rand_words < CALM_WORDS);
         if (stim_q.size() == 0 && in_random && !(rand_words >= RAND_WORDS && !drain))
            plan_words();
      end
      req_valid <= 1'b0;
      while (frame_bytes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
